>>> hw/rtl/cfp_pkg.sv
`timescale 1ns / 1ps

package cfp_pkg;

   // frame constants
   localparam logic [7:0] HDR_FIRST    = 8'hAA;
   localparam logic [7:0] HDR_SECOND   = 8'hBB;
   localparam logic [7:0] HDR_SUM      = 8'h65;  // low byte of 0xAA + 0xBB
   localparam logic [7:0] CMD_SET_ALL  = 8'h01;
   localparam logic [7:0] CMD_THROTTLE = 8'h02;
   localparam int unsigned BODY_LEN    = 5;
   localparam int unsigned VALUE_CNT   = 4;

   localparam logic [15:0] THRUST_LIMIT_RST = 16'd3825;

   typedef logic [11:0] thrust_type;

   // one completed frame as reported on the result channel
   typedef struct packed {
      logic        checksum_ok;
      logic [7:0]  command;
      logic [31:0] payload_word;
      thrust_type  thrust_a;
      thrust_type  thrust_b;
      thrust_type  thrust_c;
      thrust_type  thrust_d;
      logic        thrust_accepted;
      thrust_type  throttle_value;
      logic        pid_enabled;
   } result_type;

   // byte times 15 as (v << 4) - v
   function automatic thrust_type scale15(input logic [7:0] v);
      scale15 = {v, 4'b0000} - {4'b0000, v};
   endfunction

endpackage

>>> hw/rtl/command_frame_parser_unit.sv
`timescale 1ns / 1ps
// path: the checksum byte is held in the input register, then the decoded result word
// is loaded into the result register
// throughput: one byte per cycle; the only stall is a frame end meeting a full result register
// reset: synchronous active-high reset returns the hunt to idle, clears the pid flag
// and loads thrust_limit with 3825

module command_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // config write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_thrust_limit,
   // frame result
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_checksum_ok,
   output logic [7:0]  rsp_command,
   output logic [31:0] rsp_payload_word,
   output logic [11:0] rsp_thrust_a,
   output logic [11:0] rsp_thrust_b,
   output logic [11:0] rsp_thrust_c,
   output logic [11:0] rsp_thrust_d,
   output logic        rsp_thrust_accepted,
   output logic [11:0] rsp_throttle_value,
   output logic        rsp_pid_enabled
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_ARMED = 2'd1;
   localparam logic [1:0] PH_BODY  = 2'd2;

   localparam logic [2:0] LAST_CNT = 3'(cfp_pkg::BODY_LEN);

   logic [15:0]         limit_ff;
   logic                s1_valid_ff;
   logic [7:0]          s1_byte_ff;
   logic [1:0]          phase_ff, phase_in;
   logic [2:0]          count_ff, count_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          body_ff [cfp_pkg::BODY_LEN];
   logic                flag_ff;
   logic                out_valid_ff;
   cfp_pkg::result_type out_ff;
   cfp_pkg::result_type dec_result;
   logic                frame_end, out_free, advance, s1_load;

   // config register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= cfp_pkg::THRUST_LIMIT_RST;
      end else if (csr_valid) begin
         limit_ff <= csr_thrust_limit;
      end
   end

   // pipeline control
   assign frame_end = (phase_ff == PH_BODY) && (count_ff == LAST_CNT);
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && (!frame_end || out_free);
   assign req_ready = !s1_valid_ff || advance;
   assign s1_load   = req_valid && req_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_byte_ff <= req_rx_byte;
      end
   end

   // header hunt and body collection
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (s1_byte_ff == cfp_pkg::HDR_FIRST) phase_in = PH_ARMED;
         end
         PH_ARMED: begin
            if (s1_byte_ff == cfp_pkg::HDR_SECOND) begin
               phase_in = PH_BODY;
               count_in = 3'd0;
               sum_in   = cfp_pkg::HDR_SUM;
            end else if (s1_byte_ff != cfp_pkg::HDR_FIRST) begin
               phase_in = PH_IDLE;
            end
         end
         PH_BODY: begin
            if (count_ff == LAST_CNT) begin
               phase_in = PH_IDLE;
               count_in = 3'd0;
               sum_in   = 8'd0;
            end else begin
               count_in = count_ff + 3'd1;
               sum_in   = sum_ff + s1_byte_ff;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= 3'd0;
         sum_ff   <= 8'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // body byte store, one slot per position
   always_ff @(posedge clock) begin
      for (int i = 0; i < cfp_pkg::BODY_LEN; i++) begin
         if (advance && (phase_ff == PH_BODY) && (count_ff == 3'(i))) begin
            body_ff[i] <= s1_byte_ff;
         end
      end
   end

   // frame decode on the checksum byte
   cfp_frame_decode u_decode (
      .body_0       (body_ff[0]),
      .body_1       (body_ff[1]),
      .body_2       (body_ff[2]),
      .body_3       (body_ff[3]),
      .body_4       (body_ff[4]),
      .check_byte   (s1_byte_ff),
      .running_sum  (sum_ff),
      .thrust_limit (limit_ff),
      .flag_now     (flag_ff),
      .result       (dec_result)
   );

   // closed-loop flag
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else if (advance && frame_end) begin
         flag_ff <= dec_result.pid_enabled;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && frame_end) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (advance && frame_end) begin
         out_ff <= dec_result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_checksum_ok     = out_ff.checksum_ok;
   assign rsp_command         = out_ff.command;
   assign rsp_payload_word    = out_ff.payload_word;
   assign rsp_thrust_a        = out_ff.thrust_a;
   assign rsp_thrust_b        = out_ff.thrust_b;
   assign rsp_thrust_c        = out_ff.thrust_c;
   assign rsp_thrust_d        = out_ff.thrust_d;
   assign rsp_thrust_accepted = out_ff.thrust_accepted;
   assign rsp_throttle_value  = out_ff.throttle_value;
   assign rsp_pid_enabled     = out_ff.pid_enabled;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_CNT)
      else $error("body count out of range");

   a_count_body: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 3'd0) |-> (phase_ff == PH_BODY))
      else $error("body count set outside a frame");

   a_accept_cmd: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.thrust_accepted) |->
         (out_ff.checksum_ok && (out_ff.command == cfp_pkg::CMD_SET_ALL)))
      else $error("thrust accepted on a frame that does not allow it");

   a_pid_set: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.checksum_ok && (out_ff.command == cfp_pkg::CMD_THROTTLE))
         |-> (out_ff.pid_enabled && flag_ff))
      else $error("throttle frame did not set the pid flag");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && s1_valid_ff && frame_end) |=> $stable(phase_ff))
      else $error("frame end consumed while result register was full");

endmodule

>>> hw/rtl/cfp_frame_decode.sv
`timescale 1ns / 1ps

module cfp_frame_decode (
   input  logic [7:0]           body_0,
   input  logic [7:0]           body_1,
   input  logic [7:0]           body_2,
   input  logic [7:0]           body_3,
   input  logic [7:0]           body_4,
   input  logic [7:0]           check_byte,
   input  logic [7:0]           running_sum,
   input  logic [15:0]          thrust_limit,
   input  logic                 flag_now,
   output cfp_pkg::result_type  result
);

   logic                ok;
   cfp_pkg::thrust_type th_a, th_b, th_c, th_d;
   logic                in_limit;

   // scaled thrust values
   assign th_a = cfp_pkg::scale15(body_1);
   assign th_b = cfp_pkg::scale15(body_2);
   assign th_c = cfp_pkg::scale15(body_3);
   assign th_d = cfp_pkg::scale15(body_4);

   assign ok = (check_byte == running_sum);

   // all four thrusts not above the limit
   assign in_limit = ({4'b0000, th_a} <= thrust_limit) && ({4'b0000, th_b} <= thrust_limit)
                  && ({4'b0000, th_c} <= thrust_limit) && ({4'b0000, th_d} <= thrust_limit);

   // assemble the result word
   always_comb begin
      result.checksum_ok     = ok;
      result.command         = body_0;
      result.payload_word    = {body_4, body_3, body_2, body_1};
      result.thrust_a        = th_a;
      result.thrust_b        = th_b;
      result.thrust_c        = th_c;
      result.thrust_d        = th_d;
      result.throttle_value  = th_a;
      result.thrust_accepted = 1'b0;
      result.pid_enabled     = flag_now;
      if (ok && (body_0 == cfp_pkg::CMD_SET_ALL)) begin
         result.pid_enabled     = 1'b0;
         result.thrust_accepted = in_limit;
      end else if (ok && (body_0 == cfp_pkg::CMD_THROTTLE)) begin
         result.pid_enabled = 1'b1;
      end
   end

endmodule
